// File: rtl/core/acw_pkg.sv
// Shared types, constants and helpers of the chunk chain walker.
`default_nettype none

package acw_pkg;

   localparam int OFFSET_BITS = 40;          // width of the byte offsets
   localparam int OUT_W       = 40;          // width of chunk_start and file_end
   localparam int LEN_W       = 33;          // width of chunk_length
   localparam int CNT_W       = 5;           // header byte counter
   localparam int HDR_BYTES   = 20;
   localparam int HDR_LAST    = HDR_BYTES - 1;
   localparam int CAP_DEPTH   = HDR_BYTES - 1;   // last header byte is used straight from the input

   localparam int WVPK_EXTRA    = 8;
   localparam int APE_EXTRA     = 32;
   localparam int TAG_SKIP      = 128;
   localparam int MIN_WVPK_SIZE = 24;

   localparam int QUEUE_DEPTH = 4;           // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   // Magic words, little-endian over the captured bytes
   localparam logic [31:0] MAGIC_WVPK   = 32'h6B70_7677;   // "wvpk"
   localparam logic [31:0] MAGIC_APE_LO = 32'h5445_5041;   // "APET"
   localparam logic [31:0] MAGIC_APE_HI = 32'h5845_4741;   // "AGEX"
   localparam logic [23:0] MAGIC_TAG    = 24'h47_4154;     // "TAG"

   typedef enum logic [2:0] {
      KIND_AUDIO   = 3'd0,
      KIND_APE     = 3'd1,
      KIND_ID3     = 3'd2,
      KIND_UNKNOWN = 3'd3,
      KIND_REJECT  = 3'd4
   } acw_kind_type;

   typedef enum logic [2:0] {
      PH_FIRST = 3'b001,
      PH_WALK  = 3'b010,
      PH_STOP  = 3'b100
   } acw_phase_type;

   // One judged chunk, as passed from the front to the back
   typedef struct packed {
      acw_kind_type            kind;
      logic [OFFSET_BITS-1:0]  start;
      logic [31:0]             size;
      logic [OFFSET_BITS-1:0]  file_end;
   } acw_rec_type;

   function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                      input logic [LEN_W-1:0] b);
      logic [OFFSET_BITS:0] sum;
      sum = {1'b0, a} + (OFFSET_BITS+1)'(b);
      if (sum >= {1'b0, OFF_MAX})
         return OFF_MAX;
      return sum[OFFSET_BITS-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] out_mask(input logic [OFFSET_BITS-1:0] x);
      logic [OUT_W+OFFSET_BITS-1:0] wide;
      wide = {{OUT_W{1'b0}}, x};
      return wide[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/acw_req_if.sv
// Byte channel into the chunk chain walker.
`default_nettype none

interface acw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/core/acw_rsp_if.sv
// Result channel out of the chunk chain walker.
`default_nettype none

interface acw_rsp_if import acw_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [2:0]            chunk_kind;
   logic [OUT_W-1:0]      chunk_start;
   logic [LEN_W-1:0]      chunk_length;
   logic [OUT_W-1:0]      file_end;

   modport source (output valid, output chunk_kind, output chunk_start, output chunk_length,
                   output file_end, input ready);
   modport sink   (input valid, input chunk_kind, input chunk_start, input chunk_length,
                   input file_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/acw_front.sv
// Front end: counts bytes, captures chunk headers and classifies each chunk.
`default_nettype none

module acw_front import acw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   acw_req_if.sink     req,
   input  logic        queue_full,
   output logic        push,
   output acw_rec_type push_rec
);

   logic [OFFSET_BITS-1:0] off_ff, off_in, off_cur;
   logic [OFFSET_BITS-1:0] next_ff, next_in, next_cur;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, cnt_cur;
   acw_phase_type          phase_ff, phase_in, phase_cur;
   logic [7:0]             cap_ff [CAP_DEPTH];
   logic [LEN_W-1:0]       len_wv_ff, len_ape_ff;
   logic [OFFSET_BITS-1:0] sum_wv_ff, sum_ape_ff, sum_tag_ff;
   logic [OFFSET_BITS:0]   exp_pos;
   logic [31:0]            size_wv, size_ape;
   logic                   accept, take, judge;
   logic                   m_wv, m_ape, m_tag, idx_zero, size_ok;
   acw_rec_type            rec;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign size_wv  = {cap_ff[7], cap_ff[6], cap_ff[5], cap_ff[4]};
   assign size_ape = {cap_ff[15], cap_ff[14], cap_ff[13], cap_ff[12]};
   assign m_wv     = {cap_ff[3], cap_ff[2], cap_ff[1], cap_ff[0]} == MAGIC_WVPK;
   assign m_ape    = ({cap_ff[3], cap_ff[2], cap_ff[1], cap_ff[0]} == MAGIC_APE_LO) &&
                     ({cap_ff[7], cap_ff[6], cap_ff[5], cap_ff[4]} == MAGIC_APE_HI);
   assign m_tag    = {cap_ff[2], cap_ff[1], cap_ff[0]} == MAGIC_TAG;
   assign idx_zero = (cap_ff[16] == 8'h00) && (cap_ff[17] == 8'h00) &&
                     (cap_ff[18] == 8'h00) && (req.data_byte == 8'h00);
   assign size_ok  = size_wv >= 32'(MIN_WVPK_SIZE);

   always_comb begin
      // A start mark restarts the walk before its byte is taken
      if (req.start_of_file) begin
         off_cur   = '0;
         next_cur  = '0;
         cnt_cur   = '0;
         phase_cur = PH_FIRST;
      end else begin
         off_cur   = off_ff;
         next_cur  = next_ff;
         cnt_cur   = cnt_ff;
         phase_cur = phase_ff;
      end

      off_in  = (off_cur == OFF_MAX) ? off_cur : off_cur + OFFSET_BITS'(1);
      exp_pos = {1'b0, next_cur} + (OFFSET_BITS+1)'(cnt_cur);
      take    = (phase_cur != PH_STOP) && ({1'b0, off_cur} == exp_pos);
      judge   = take && (cnt_cur == CNT_W'(HDR_LAST));

      rec.kind     = KIND_UNKNOWN;
      rec.start    = next_cur;
      rec.size     = size_wv;
      next_in      = next_cur;
      phase_in     = phase_cur;

      case (phase_cur)
         PH_FIRST: begin
            if (m_wv && idx_zero && size_ok) begin
               rec.kind = KIND_AUDIO;
               next_in  = sum_wv_ff;
               phase_in = PH_WALK;
            end else begin
               rec.kind  = KIND_REJECT;
               rec.start = '0;
               phase_in  = PH_STOP;
            end
         end
         PH_WALK: begin
            if (m_wv) begin
               rec.kind = KIND_AUDIO;
               next_in  = sum_wv_ff;
            end else if (m_ape) begin
               rec.kind = KIND_APE;
               rec.size = size_ape;
               next_in  = sum_ape_ff;
            end else if (m_tag) begin
               rec.kind = KIND_ID3;
               next_in  = sum_tag_ff;
            end else begin
               phase_in = PH_STOP;
            end
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase

      rec.file_end = (rec.kind == KIND_REJECT) ? '0 : next_in;

      if (judge) begin
         cnt_in = '0;
      end else begin
         next_in  = next_cur;
         phase_in = phase_cur;
         cnt_in   = take ? cnt_cur + CNT_W'(1) : cnt_cur;
      end
   end

   assign push     = accept && judge;
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         next_ff  <= '0;
         cnt_ff   <= '0;
         phase_ff <= PH_FIRST;
      end else if (accept) begin
         off_ff   <= off_in;
         next_ff  <= next_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   // Capture header bytes; the last one is judged straight from the input
   always_ff @(posedge clock) begin
      if (accept && take && !judge)
         cap_ff[cnt_cur] <= req.data_byte;
   end

   // Candidate next offsets, settled well before the last header byte arrives
   always_ff @(posedge clock) begin
      len_wv_ff  <= {1'b0, size_wv} + LEN_W'(WVPK_EXTRA);
      len_ape_ff <= {1'b0, size_ape} + LEN_W'(APE_EXTRA);
      sum_wv_ff  <= sat_add(next_ff, len_wv_ff);
      sum_ape_ff <= sat_add(next_ff, len_ape_ff);
      sum_tag_ff <= sat_add(next_ff, LEN_W'(TAG_SKIP));
   end

endmodule

`default_nettype wire

// File: rtl/core/acw_queue.sv
// Short queue of judged chunks between the front and the back.
`default_nettype none

module acw_queue import acw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  acw_rec_type push_rec,
   output logic        full,
   input  logic        pop,
   output acw_rec_type pop_rec,
   output logic        not_empty
);

   acw_rec_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign full      = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_rec   = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop)
         count_in = count_ff + (QPTR_W+1)'(1);
      else if (do_pop && !push)
         count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

// File: rtl/core/acw_back.sv
// Back end: works out the skip length and holds the result item for the sink.
`default_nettype none

module acw_back import acw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rec_valid,
   input  acw_rec_type rec,
   output logic        pop,
   acw_rsp_if.source   rsp
);

   logic             valid_ff;
   logic [2:0]       kind_ff;
   logic [OUT_W-1:0] start_ff, end_ff;
   logic [LEN_W-1:0] len_ff, len_in;

   assign pop = rec_valid && (!valid_ff || rsp.ready);

   always_comb begin
      case (rec.kind)
         KIND_AUDIO: len_in = {1'b0, rec.size} + LEN_W'(WVPK_EXTRA);
         KIND_APE:   len_in = {1'b0, rec.size} + LEN_W'(APE_EXTRA);
         KIND_ID3:   len_in = LEN_W'(TAG_SKIP);
         default:    len_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (pop)
         valid_ff <= 1'b1;
      else if (rsp.ready)
         valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= rec.kind;
         start_ff <= out_mask(rec.start);
         end_ff   <= out_mask(rec.file_end);
         len_ff   <= len_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.chunk_kind   = kind_ff;
   assign rsp.chunk_start  = start_ff;
   assign rsp.chunk_length = len_ff;
   assign rsp.file_end     = end_ff;

endmodule

`default_nettype wire

// File: rtl/core/audio_container_chunk_walker.sv
// Top level of the chunk chain walker: front, queue and back.
`default_nettype none

// Takes a file one byte per item and follows its chain of chunks; a start_of_file
// byte restarts the walk at offset 0, and after reset the walk starts as if the first
// byte carried that mark. The first chunk must be an audio block ("wvpk", block
// index zero, size at least 24) or the start is rejected; after that audio blocks,
// APE tags and ID3v1 tags are skipped and anything else stops the walk until the
// next start mark. One result item is given for each judged chunk; it enters the
// result queue as the byte that completes its 20-byte header is taken. The block
// takes one byte every cycle: classification and the next-offset update happen in
// the front in the cycle of the last header byte, using skip sums worked out while
// the earlier header bytes arrive. It holds back a byte only when its four-entry
// result queue is full, which happens only after the result sink has stalled.
// Offsets saturate at their largest value. No clearing pass is needed after reset.

module audio_container_chunk_walker import acw_pkg::*; (
   input logic       clock,
   input logic       reset,
   acw_req_if.sink   req_in,
   acw_rsp_if.source rsp_out
);

   logic        push, full, pop, not_empty;
   acw_rec_type push_rec, pop_rec;

   acw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_in),
      .queue_full (full),
      .push       (push),
      .push_rec   (push_rec)
   );

   acw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (full),
      .pop       (pop),
      .pop_rec   (pop_rec),
      .not_empty (not_empty)
   );

   acw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (not_empty),
      .rec       (pop_rec),
      .pop       (pop),
      .rsp       (rsp_out)
   );

endmodule

`default_nettype wire

// File: rtl/core/acw_checker.sv
// Port-level checks on the chunk chain walker's result items, and their binding.
`default_nettype none

module acw_checker import acw_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [2:0]       chunk_kind,
   input logic [OUT_W-1:0] chunk_start,
   input logic [LEN_W-1:0] chunk_length,
   input logic [OUT_W-1:0] file_end
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(chunk_kind) &&
      $stable(chunk_start) && $stable(chunk_length) && $stable(file_end))
      else $error("result item changed while stalled");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chunk_kind == KIND_REJECT |->
      chunk_start == '0 && chunk_length == '0 && file_end == '0)
      else $error("rejected start with non-zero fields");

   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chunk_kind == KIND_UNKNOWN |->
      chunk_length == '0 && file_end == chunk_start)
      else $error("unrecognised chunk moved the file end");

   a_id3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chunk_kind == KIND_ID3 |-> chunk_length == LEN_W'(TAG_SKIP))
      else $error("ID3 tag with wrong skip length");

   a_skip_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (chunk_kind == KIND_AUDIO || chunk_kind == KIND_APE) |->
      chunk_length >= LEN_W'(WVPK_EXTRA) &&
      (chunk_kind != KIND_APE || chunk_length >= LEN_W'(APE_EXTRA)))
      else $error("skip length below header overhead");

endmodule

bind audio_container_chunk_walker acw_checker u_acw_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_out.valid),
   .rsp_ready    (rsp_out.ready),
   .chunk_kind   (rsp_out.chunk_kind),
   .chunk_start  (rsp_out.chunk_start),
   .chunk_length (rsp_out.chunk_length),
   .file_end     (rsp_out.file_end)
);

`default_nettype wire
